/* rtl/core/tld_pkg.sv */
`timescale 1ns / 1ps

package tld_pkg;

   localparam int RING_DEPTH = 256;
   localparam int IDX_W      = $clog2(RING_DEPTH);
   localparam int NL_W       = $clog2(RING_DEPTH) + 1;
   localparam int DATA_W     = 8;
   localparam int OP_W       = 2;
   localparam int STATUS_W   = 2;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 1;

   typedef logic [IDX_W-1:0]  idx_type;
   typedef logic [NL_W-1:0]   nl_type;
   typedef logic [DATA_W-1:0] byte_type;

   typedef enum logic [OP_W-1:0] {
      OP_RECEIVE = 2'd0,
      OP_READ    = 2'd1,
      OP_WRITE   = 2'd2,
      OP_DRAIN   = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_NOT_READY = 2'd1,
      STATUS_TX_FULL   = 2'd2
   } status_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ECHO_ENABLE    = 1'd0,
      CSR_CANONICAL_MODE = 1'd1
   } csr_index_type;

   localparam byte_type CH_CR   = 8'd13;
   localparam byte_type CH_LF   = 8'd10;
   localparam byte_type CH_BS   = 8'd8;
   localparam byte_type CH_DEL  = 8'd127;
   localparam byte_type CH_INTR = 8'd3;
   localparam byte_type CH_SP   = 8'd32;

   typedef struct packed {
      byte_type   read_data;
      logic       read_valid;
      logic       read_end_of_line;
      byte_type   tx_data;
      logic       tx_valid;
      logic       tx_pending;
      logic       interrupt_request;
      logic       wake_reader;
      logic       wake_writer;
      status_type status;
   } result_type;

   function automatic idx_type ring_next(idx_type i);
      return (i == idx_type'(RING_DEPTH - 1)) ? '0 : i + idx_type'(1);
   endfunction

   function automatic idx_type ring_prev(idx_type i);
      return (i == '0) ? idx_type'(RING_DEPTH - 1) : i - idx_type'(1);
   endfunction

endpackage

/* rtl/core/tld_chan_if.sv */
`timescale 1ns / 1ps

interface tld_req_if;
   import tld_pkg::*;
   logic                valid;
   logic                ready;
   logic [OP_W-1:0]     operation;
   logic [DATA_W-1:0]   data_byte;

   modport source (output valid, output operation, output data_byte, input ready);
   modport sink   (input valid, input operation, input data_byte, output ready);
endinterface

interface tld_rsp_if;
   import tld_pkg::*;
   logic                valid;
   logic                ready;
   logic [DATA_W-1:0]   read_data;
   logic                read_valid;
   logic                read_end_of_line;
   logic [DATA_W-1:0]   tx_data;
   logic                tx_valid;
   logic                tx_pending;
   logic                interrupt_request;
   logic                wake_reader;
   logic                wake_writer;
   logic [STATUS_W-1:0] status;

   modport source (
      output valid, output read_data, output read_valid, output read_end_of_line,
      output tx_data, output tx_valid, output tx_pending, output interrupt_request,
      output wake_reader, output wake_writer, output status, input ready
   );
   modport sink (
      input valid, input read_data, input read_valid, input read_end_of_line,
      input tx_data, input tx_valid, input tx_pending, input interrupt_request,
      input wake_reader, input wake_writer, input status, output ready
   );
endinterface

/* rtl/core/tty_line_discipline.sv */
// Sequence from request transfer to response valid: the ring memories are read at the
//   transfer edge itself, EXEC executes, PUT writes each echo or CR/LF byte into the
//   transmit ring (zero to three), and FIN loads the response register, waiting while
//   the previous response has not been taken on rsp_chan.ready.
// One item at a time: a new request is taken only once the last one is back in IDLE.
// Reset: synchronous, active high; clears ring pointers, newline count, both control
//   registers and the response valid. Ring contents stay undefined until written.
`timescale 1ns / 1ps

module tty_line_discipline (
   input  logic                              clock,
   input  logic                              reset,
   tld_req_if.sink                           req_chan,
   tld_rsp_if.source                         rsp_chan,
   input  logic                              csr_write_enable,
   input  logic [tld_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [tld_pkg::CSR_DATA_W-1:0]    csr_write_data
);
   import tld_pkg::*;

   // Sequencer: IDLE takes a transfer and issues the ring reads, EXEC sees the
   // read data and updates pointers, PUT writes queued transmit bytes one a
   // cycle, FIN hands the result to the response register.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_PUT,
      ST_FIN
   } state_type;

   state_type  state_ff, state_in;

   // Ring pointers and line bookkeeping
   idx_type    rx_head_ff, rx_head_in;
   idx_type    rx_tail_ff, rx_tail_in;
   nl_type     nl_count_ff, nl_count_in;
   idx_type    tx_head_ff, tx_head_in;
   idx_type    tx_tail_ff, tx_tail_in;

   // Control registers
   logic       echo_ff, echo_in;
   logic       canon_ff, canon_in;

   // Current item
   op_type     op_ff;
   byte_type   byte_ff;
   result_type res_ff, res_in;

   // Transmit put queue: up to three bytes (BS SP BS, or CR LF)
   byte_type   put_byte_ff [3];
   byte_type   put_byte_in [3];
   logic [1:0] put_count_ff, put_count_in;
   logic [1:0] put_idx_ff, put_idx_in;

   // Response register
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff;
   result_type rsp_next;
   logic       rsp_load;

   // Ring memories with registered read data
   byte_type   rx_mem [RING_DEPTH];
   byte_type   tx_mem [RING_DEPTH];
   byte_type   rx_rdata_ff;
   byte_type   tx_rdata_ff;
   idx_type    rx_raddr;
   logic       rx_we;
   logic       tx_we;

   logic       accept;
   byte_type   mapped;
   logic       is_erase;
   logic       rx_ready;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;

   // Receive path turns CR into LF before anything else looks at it
   assign mapped   = (byte_ff == CH_CR) ? CH_LF : byte_ff;
   assign is_erase = (mapped == CH_BS) || (mapped == CH_DEL);
   assign rx_ready = (rx_head_ff != rx_tail_ff) && !(canon_ff && (nl_count_ff == '0));

   // A read pops at the tail; an erase looks at the byte just below the head
   assign rx_raddr = (op_type'(req_chan.operation) == OP_READ) ? rx_tail_ff
                                                               : ring_prev(rx_head_ff);

   // Memories are only written in EXEC and PUT and only read in IDLE, so the
   // sequencer itself keeps reads and writes to one entry from overlapping.
   always_ff @(posedge clock) begin
      if (rx_we) begin
         rx_mem[rx_head_ff] <= mapped;
      end
      if (accept) begin
         rx_rdata_ff <= rx_mem[rx_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (tx_we) begin
         tx_mem[tx_head_ff] <= put_byte_ff[put_idx_ff];
      end
      if (accept) begin
         tx_rdata_ff <= tx_mem[tx_tail_ff];
      end
   end

   always_comb begin
      state_in     = state_ff;
      rx_head_in   = rx_head_ff;
      rx_tail_in   = rx_tail_ff;
      nl_count_in  = nl_count_ff;
      tx_head_in   = tx_head_ff;
      tx_tail_in   = tx_tail_ff;
      res_in       = res_ff;
      put_byte_in  = put_byte_ff;
      put_count_in = put_count_ff;
      put_idx_in   = put_idx_ff;
      rx_we        = 1'b0;
      tx_we        = 1'b0;
      rsp_load     = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;

      echo_in  = echo_ff;
      canon_in = canon_ff;
      if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_ECHO_ENABLE:    echo_in  = csr_write_data[0];
            CSR_CANONICAL_MODE: canon_in = csr_write_data[0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
            end
         end

         ST_EXEC: begin
            res_in       = '0;
            res_in.status = STATUS_OK;
            put_count_in = 2'd0;
            put_idx_in   = 2'd0;
            put_byte_in[0] = '0;
            put_byte_in[1] = '0;
            put_byte_in[2] = '0;

            case (op_ff)
               OP_RECEIVE: begin
                  if (mapped == CH_INTR) begin
                     res_in.interrupt_request = 1'b1;
                  end else if (canon_ff && is_erase) begin
                     // Erase the last stored byte; nothing happens on an empty ring
                     if (rx_head_ff != rx_tail_ff) begin
                        rx_head_in = ring_prev(rx_head_ff);
                        if ((rx_rdata_ff == CH_LF) && (nl_count_ff != '0)) begin
                           nl_count_in = nl_count_ff - nl_type'(1);
                        end
                        if (echo_ff) begin
                           put_byte_in[0] = CH_BS;
                           put_byte_in[1] = CH_SP;
                           put_byte_in[2] = CH_BS;
                           put_count_in   = 2'd3;
                        end
                     end
                  end else begin
                     if (echo_ff) begin
                        if (is_erase) begin
                           put_byte_in[0] = CH_BS;
                           put_byte_in[1] = CH_SP;
                           put_byte_in[2] = CH_BS;
                           put_count_in   = 2'd3;
                        end else if (mapped == CH_LF) begin
                           put_byte_in[0] = CH_CR;
                           put_byte_in[1] = CH_LF;
                           put_count_in   = 2'd2;
                        end else begin
                           put_byte_in[0] = mapped;
                           put_count_in   = 2'd1;
                        end
                     end
                     // Store, or drop silently on a full ring
                     if (ring_next(rx_head_ff) != rx_tail_ff) begin
                        rx_we      = 1'b1;
                        rx_head_in = ring_next(rx_head_ff);
                        if (mapped == CH_LF) begin
                           nl_count_in = nl_count_ff + nl_type'(1);
                        end
                     end
                     res_in.wake_reader = !canon_ff || (mapped == CH_LF);
                  end
               end

               OP_READ: begin
                  if (!rx_ready) begin
                     res_in.status = STATUS_NOT_READY;
                  end else begin
                     res_in.read_data  = rx_rdata_ff;
                     res_in.read_valid = 1'b1;
                     rx_tail_in        = ring_next(rx_tail_ff);
                     if (rx_rdata_ff == CH_LF) begin
                        if (nl_count_ff != '0) begin
                           nl_count_in = nl_count_ff - nl_type'(1);
                        end
                        res_in.read_end_of_line = canon_ff;
                     end
                  end
               end

               OP_WRITE: begin
                  // Report full instead of blocking; CR goes ahead of LF
                  if (ring_next(tx_head_ff) == tx_tail_ff) begin
                     res_in.status = STATUS_TX_FULL;
                  end else if (byte_ff == CH_LF) begin
                     put_byte_in[0] = CH_CR;
                     put_byte_in[1] = CH_LF;
                     put_count_in   = 2'd2;
                  end else begin
                     put_byte_in[0] = byte_ff;
                     put_count_in   = 2'd1;
                  end
               end

               OP_DRAIN: begin
                  if (tx_head_ff != tx_tail_ff) begin
                     res_in.tx_data     = tx_rdata_ff;
                     res_in.tx_valid    = 1'b1;
                     res_in.wake_writer = 1'b1;
                     tx_tail_in         = ring_next(tx_tail_ff);
                  end
               end

               default: ;
            endcase

            state_in = (put_count_in != 2'd0) ? ST_PUT : ST_FIN;
         end

         ST_PUT: begin
            // One transmit byte per cycle; each put checks for room on its own
            if (ring_next(tx_head_ff) != tx_tail_ff) begin
               tx_we      = 1'b1;
               tx_head_in = ring_next(tx_head_ff);
            end
            put_idx_in = put_idx_ff + 2'd1;
            if (put_idx_ff == put_count_ff - 2'd1) begin
               state_in = ST_FIN;
            end
         end

         ST_FIN: begin
            // Hold here while the previous response has not been taken
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_load     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rx_head_ff   <= '0;
         rx_tail_ff   <= '0;
         nl_count_ff  <= '0;
         tx_head_ff   <= '0;
         tx_tail_ff   <= '0;
         echo_ff      <= 1'b0;
         canon_ff     <= 1'b0;
         put_count_ff <= 2'd0;
         put_idx_ff   <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rx_head_ff   <= rx_head_in;
         rx_tail_ff   <= rx_tail_in;
         nl_count_ff  <= nl_count_in;
         tx_head_ff   <= tx_head_in;
         tx_tail_ff   <= tx_tail_in;
         echo_ff      <= echo_in;
         canon_ff     <= canon_in;
         put_count_ff <= put_count_in;
         put_idx_ff   <= put_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Finished result with the transmit ring level as it stands after the puts
   always_comb begin
      rsp_next            = res_ff;
      rsp_next.tx_pending = (tx_head_ff != tx_tail_ff);
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff   <= op_type'(req_chan.operation);
         byte_ff <= req_chan.data_byte;
      end
      res_ff      <= res_in;
      put_byte_ff <= put_byte_in;
      if (rsp_load) begin
         rsp_ff <= rsp_next;
      end
   end

   assign rsp_chan.valid             = rsp_valid_ff;
   assign rsp_chan.read_data         = rsp_ff.read_data;
   assign rsp_chan.read_valid        = rsp_ff.read_valid;
   assign rsp_chan.read_end_of_line  = rsp_ff.read_end_of_line;
   assign rsp_chan.tx_data           = rsp_ff.tx_data;
   assign rsp_chan.tx_valid          = rsp_ff.tx_valid;
   assign rsp_chan.tx_pending        = rsp_ff.tx_pending;
   assign rsp_chan.interrupt_request = rsp_ff.interrupt_request;
   assign rsp_chan.wake_reader       = rsp_ff.wake_reader;
   assign rsp_chan.wake_writer       = rsp_ff.wake_writer;
   assign rsp_chan.status            = rsp_ff.status;

   // An empty receive ring holds no newline
   a_empty_no_lines: assert property (@(posedge clock) disable iff (reset)
      (rx_head_ff == rx_tail_ff) |-> (nl_count_ff == '0))
      else $error("newline count nonzero on empty receive ring");

   // A stalled response keeps the finished item parked in FIN
   a_fin_interlock: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIN && rsp_valid_ff && !rsp_chan.ready) |=> (state_ff == ST_FIN))
      else $error("left FIN while response register still occupied");

   // Put index stays inside the queued byte count
   a_put_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PUT) |-> (put_idx_ff < put_count_ff))
      else $error("transmit put index beyond queued bytes");

endmodule
